[design/cov2_pkg.sv]
`default_nettype none

package cov2_pkg;

	// Fixed field widths of the sample and result transactions
	localparam int SAMPLE_BITS  = 16;
	localparam int VAR_W        = 31;
	localparam int COV_W        = 32;
	localparam int PAIR_COUNT_W = 11;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x_sample;
		logic signed [SAMPLE_BITS-1:0] y_sample;
		logic                          last_sample;
	} item_t;

	typedef struct packed {
		logic        [VAR_W-1:0]        variance_x;
		logic        [VAR_W-1:0]        variance_y;
		logic signed [COV_W-1:0]        covariance_xy;
		logic        [PAIR_COUNT_W-1:0] pair_count;
		logic                           overflowed;
	} result_t;

	// Which statistic the shared finish path is working on
	typedef enum logic [1:0] {
		STAT_VX,
		STAT_VY,
		STAT_CXY
	} stat_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      accept;
		logic      mul;
		logic      sub;
		logic      absv;
		logic      div_start;
		logic      store;
		logic      clear;
		stat_sel_t sel;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

`default_nettype wire

[design/cov2_div.sv]
`default_nettype none

module cov2_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 22
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] numer,
	input  wire logic [DEN_W-1:0] denom,
	output logic      [NUM_W-1:0] quot,
	output logic                  done
);

	localparam int IW = $clog2(NUM_W + 1);

	logic             running_q;
	logic [IW-1:0]    iter_q;
	logic             done_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;

	// Restoring step: shift in one numerator bit, try to subtract the divisor
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
	end

	// Control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			iter_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				iter_q    <= IW'(NUM_W);
			end else if (running_q) begin
				iter_q <= iter_q - IW'(1);
				if (iter_q == IW'(1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (running_q) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule

`default_nettype wire

[design/cov2_datapath.sv]
`default_nettype none

module cov2_datapath #(
	parameter int MAX_SAMPLES = 1024,
	parameter int CNT_W       = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cov2_pkg::item_t   item,
	input  wire cov2_pkg::cmd_t    cmd,
	output cov2_pkg::status_t      status,
	output cov2_pkg::result_t      result
);

	localparam int SB    = cov2_pkg::SAMPLE_BITS;
	localparam int PR_W  = 2 * SB;
	localparam int SX_W  = SB + CNT_W;
	localparam int SQ_W  = 2 * SB + CNT_W;
	localparam int NUM_W = SQ_W + CNT_W + 2;
	localparam int NS_W  = NUM_W - 1;
	localparam int PS_W  = 2 * SX_W;
	localparam int DEN_W = 2 * CNT_W;
	localparam int VW    = cov2_pkg::VAR_W;
	localparam int CW    = cov2_pkg::COV_W;

	// Sample stage and running sums
	logic                    vld_s1;
	logic signed [SB-1:0]    x_s1;
	logic signed [SB-1:0]    y_s1;
	logic signed [PR_W-1:0]  xx_s1;
	logic signed [PR_W-1:0]  yy_s1;
	logic signed [PR_W-1:0]  xy_s1;
	logic signed [SX_W-1:0]  sum_x_q;
	logic signed [SX_W-1:0]  sum_y_q;
	logic signed [SQ_W-1:0]  sum_xx_q;
	logic signed [SQ_W-1:0]  sum_yy_q;
	logic signed [SQ_W-1:0]  sum_xy_q;
	logic        [CNT_W-1:0] cnt_q;
	logic                    ovf_q;
	logic                    room;

	// Finish path
	logic signed [SQ_W-1:0]   sab;
	logic signed [SX_W-1:0]   sa;
	logic signed [SX_W-1:0]   sb;
	logic signed [NUM_W-2:0]  nsab_q;
	logic signed [2*SX_W-1:0] sasb_q;
	logic        [DEN_W-1:0]  den_q;
	logic                     nz_q;
	logic signed [NUM_W-1:0]  diff_q;
	logic        [NUM_W-1:0]  mag_q;
	logic                     neg_q;
	logic        [NUM_W-1:0]  quot;
	logic                     div_done;
	logic                     sat_pos;
	logic                     sat_neg;
	logic        [CW-1:0]     pos_val;
	logic        [CW-1:0]     neg_val;
	logic        [CW-1:0]     cov_val;
	logic        [VW-1:0]     var_val;
	cov2_pkg::result_t        result_q;

	assign room = cnt_q < CNT_W'(MAX_SAMPLES);

	// Register the pair and its products on every accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_s1  <= item.x_sample;
			y_s1  <= item.y_sample;
			xx_s1 <= PR_W'(item.x_sample) * PR_W'(item.x_sample);
			yy_s1 <= PR_W'(item.y_sample) * PR_W'(item.y_sample);
			xy_s1 <= PR_W'(item.x_sample) * PR_W'(item.y_sample);
		end
	end

	// Accumulate, count and flag extra pairs; clear after a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
		end else begin
			vld_s1 <= cmd.accept && room;
			if (cmd.clear) begin
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				sum_xx_q <= '0;
				sum_yy_q <= '0;
				sum_xy_q <= '0;
				cnt_q    <= '0;
				ovf_q    <= 1'b0;
			end else begin
				if (vld_s1) begin
					sum_x_q  <= sum_x_q + SX_W'(x_s1);
					sum_y_q  <= sum_y_q + SX_W'(y_s1);
					sum_xx_q <= sum_xx_q + SQ_W'(xx_s1);
					sum_yy_q <= sum_yy_q + SQ_W'(yy_s1);
					sum_xy_q <= sum_xy_q + SQ_W'(xy_s1);
				end
				if (cmd.accept && room) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (cmd.accept && !room) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Select the sums for the current statistic
	always_comb begin
		case (cmd.sel)
			cov2_pkg::STAT_VX: begin
				sab = sum_xx_q;
				sa  = sum_x_q;
				sb  = sum_x_q;
			end
			cov2_pkg::STAT_VY: begin
				sab = sum_yy_q;
				sa  = sum_y_q;
				sb  = sum_y_q;
			end
			cov2_pkg::STAT_CXY: begin
				sab = sum_xy_q;
				sa  = sum_x_q;
				sb  = sum_y_q;
			end
			default: begin
				sab = '0;
				sa  = '0;
				sb  = '0;
			end
		endcase
	end

	// Products, numerator, then its magnitude, one step per command
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			nsab_q <= NS_W'($signed({1'b0, cnt_q})) * NS_W'(sab);
			sasb_q <= PS_W'(sa) * PS_W'(sb);
			den_q  <= DEN_W'(cnt_q) * DEN_W'(cnt_q);
			nz_q   <= cnt_q != '0;
		end
		if (cmd.sub) begin
			diff_q <= NUM_W'(nsab_q) - NUM_W'(sasb_q);
		end
		if (cmd.absv) begin
			neg_q <= diff_q[NUM_W-1];
			mag_q <= diff_q[NUM_W-1] ? NUM_W'(-diff_q) : NUM_W'(diff_q);
		end
	end

	cov2_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.numer (mag_q),
		.denom (den_q),
		.quot  (quot),
		.done  (div_done)
	);

	// Apply sign and saturate the quotient
	always_comb begin
		sat_pos = |quot[NUM_W-1:CW-1];
		sat_neg = (|quot[NUM_W-1:CW]) || (quot[CW-1] && (|quot[CW-2:0]));
		pos_val = sat_pos ? {1'b0, {(CW-1){1'b1}}} : {1'b0, quot[CW-2:0]};
		neg_val = sat_neg ? {1'b1, {(CW-1){1'b0}}} : CW'(-quot[CW-1:0]);
		if (!nz_q) begin
			cov_val = '0;
		end else if (neg_q) begin
			cov_val = neg_val;
		end else begin
			cov_val = pos_val;
		end
		var_val = (!nz_q || neg_q) ? '0 : pos_val[VW-1:0];
	end

	// Hold each statistic; the covariance closes the result
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			case (cmd.sel)
				cov2_pkg::STAT_VX: begin
					result_q.variance_x <= var_val;
				end
				cov2_pkg::STAT_VY: begin
					result_q.variance_y <= var_val;
				end
				cov2_pkg::STAT_CXY: begin
					result_q.covariance_xy <= cov_val;
					result_q.pair_count    <= cov2_pkg::PAIR_COUNT_W'(cnt_q);
					result_q.overflowed    <= ovf_q;
				end
				default: begin
					result_q <= result_q;
				end
			endcase
		end
	end

	assign status.div_done = div_done;
	assign result          = result_q;

endmodule

`default_nettype wire

[design/cov2_ctrl.sv]
`default_nettype none

module cov2_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              last,
	input  wire cov2_pkg::status_t status,
	output cov2_pkg::cmd_t         cmd,
	output logic                   busy,
	output logic                   done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DRAIN,
		S_MUL,
		S_SUB,
		S_ABS,
		S_DIV,
		S_WAIT
	} state_t;

	state_t              state_q;
	cov2_pkg::stat_sel_t sel_q;
	logic                busy_q;
	logic                done_q;
	logic                store;

	assign store = (state_q == S_WAIT) && status.div_done;

	// Decode commands from the state
	always_comb begin
		cmd.accept    = start && !busy_q;
		cmd.mul       = state_q == S_MUL;
		cmd.sub       = state_q == S_SUB;
		cmd.absv      = state_q == S_ABS;
		cmd.div_start = state_q == S_DIV;
		cmd.store     = store;
		cmd.clear     = store && (sel_q == cov2_pkg::STAT_CXY);
		cmd.sel       = sel_q;
	end

	// State, statistic select and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= cov2_pkg::STAT_VX;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && !busy_q && last) begin
						state_q <= S_DRAIN;
						sel_q   <= cov2_pkg::STAT_VX;
						busy_q  <= 1'b1;
					end
				end
				S_DRAIN: state_q <= S_MUL;
				S_MUL:   state_q <= S_SUB;
				S_SUB:   state_q <= S_ABS;
				S_ABS:   state_q <= S_DIV;
				S_DIV:   state_q <= S_WAIT;
				S_WAIT: begin
					if (status.div_done) begin
						case (sel_q)
							cov2_pkg::STAT_VX: begin
								sel_q   <= cov2_pkg::STAT_VY;
								state_q <= S_MUL;
							end
							cov2_pkg::STAT_VY: begin
								sel_q   <= cov2_pkg::STAT_CXY;
								state_q <= S_MUL;
							end
							default: begin
								state_q <= S_IDLE;
								busy_q  <= 1'b0;
								done_q  <= 1'b1;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

[design/covariance_2d_accumulator.sv]
// Throughput: one sample transaction per cycle while busy is low.
// done strobes after the last pair is taken, once the bit-serial divider, of width
//   2*SAMPLE_BITS+2*clog2(MAX_SAMPLES+1)+2, has run once per statistic. busy is high meanwhile.
// The receiver cannot stall: each result shows for one cycle under done.
// Reset: arst_n clears all sums, the pair count, the overflow flag and the controller.
`default_nettype none

module covariance_2d_accumulator #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire cov2_pkg::item_t   item,
	output logic                   busy,
	output logic                   done,
	output cov2_pkg::result_t      result
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	cov2_pkg::cmd_t    cmd;
	cov2_pkg::status_t status;

	cov2_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.last  (item.last_sample),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	cov2_datapath #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.CNT_W      (CNT_W)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.status(status),
		.result(result)
	);

endmodule

`default_nettype wire
